@@ sv/indexed_list_engine_unit_assert.svh @@
// assertion macros shared by the checker of the list engine
// needs clk_i and rst_ni in the scope where a macro is used
`ifndef INDEXED_LIST_ENGINE_UNIT_ASSERT_SVH
`define INDEXED_LIST_ENGINE_UNIT_ASSERT_SVH

// clocked property, switched off while reset is held
`define ILE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked property that also holds during reset
`define ILE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ sv/ile_pkg.sv @@
// command and status codes and cell control type for the list engine
// no dependencies
package ile_pkg;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_MEMBER = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // what every cell does at the next edge
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_WR
  } cell_op_e;

endpackage

@@ sv/indexed_list_engine_unit.sv @@
// top level of the list engine: command decode, count and a row of ile_cell
// depends on ile_pkg and ile_cell
//
// channel   | signals                                    | handshake
// ----------+--------------------------------------------+--------------------------
// command   | cmd_i, position_i, item_value_i            | start high, busy low
// result    | read_value_o, found_o, item_count_o,       | done_o high for one cycle
//           | status_o                                   |
//
// one command per cycle: every cell shifts, writes and compares at once, so the
// whole row moves in the edge that accepts the command
// the result follows on the outputs in the next cycle, marked by done_o
// busy stays low; results cannot be held off by the receiver
// reset clears the count and done_o only; cell contents stay undefined until written
module indexed_list_engine_unit #(
  parameter int unsigned CAPACITY  = 64,
  parameter int unsigned ITEM_BITS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [ile_pkg::CMD_W-1:0]          cmd_i,
  input  logic [$clog2(CAPACITY+1)-1:0]      position_i,
  input  logic [ITEM_BITS-1:0]               item_value_i,
  output logic                               done_o,
  output logic [ITEM_BITS-1:0]               read_value_o,
  output logic                               found_o,
  output logic [$clog2(CAPACITY+1)-1:0]      item_count_o,
  output logic [ile_pkg::STATUS_W-1:0]       status_o
);
  import ile_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = $clog2(CAPACITY);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic                 accept;
  logic [CW-1:0]        count_q, count_d;
  logic                 full, pos_ok;
  cell_op_e             op;
  logic [IW-1:0]        idx;
  logic [ITEM_BITS-1:0] rd_any;
  logic                 hit_any;
  logic [ITEM_BITS-1:0] rd_d;
  logic                 found_d;
  logic [STATUS_W-1:0]  status_d;

  logic [ITEM_BITS-1:0] data_w [CAPACITY];
  logic [ITEM_BITS-1:0] rd_w   [CAPACITY];
  logic [CAPACITY-1:0]  match_w;

  logic                 done_q;
  logic [ITEM_BITS-1:0] rd_q;
  logic                 found_q;
  logic [CW-1:0]        cnt_out_q;
  logic [STATUS_W-1:0]  status_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_q >= CAP_C);
  assign pos_ok = (position_i != '0) && (position_i <= count_q);

  always_comb begin
    op       = CELL_HOLD;
    idx      = IW'(position_i - CW'(1));
    count_d  = count_q;
    status_d = ST_OK;
    rd_d     = '0;
    found_d  = 1'b0;
    unique case (cmd_i)
      CMD_APPEND, CMD_INSERT: begin
        // slot at or past the count appends
        if (cmd_i == CMD_INSERT && position_i < count_q) begin
          idx = position_i[IW-1:0];
        end else begin
          idx = count_q[IW-1:0];
        end
        if (full) begin
          status_d = ST_FULL;
        end else begin
          op      = CELL_INS;
          count_d = count_q + CW'(1);
        end
      end
      CMD_REMOVE: begin
        if (!pos_ok) begin
          status_d = ST_RANGE;
        end else begin
          op      = CELL_DEL;
          count_d = count_q - CW'(1);
        end
      end
      CMD_READ: begin
        if (!pos_ok) begin
          status_d = ST_RANGE;
        end else begin
          rd_d = rd_any;
        end
      end
      CMD_WRITE: begin
        if (!pos_ok) begin
          status_d = ST_RANGE;
        end else begin
          op = CELL_WR;
        end
      end
      CMD_MEMBER: found_d = hit_any;
      default: ;
    endcase
    if (!accept) begin
      op      = CELL_HOLD;
      count_d = count_q;
    end
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [ITEM_BITS-1:0] left_w, right_w;
    if (k == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = data_w[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right_w = data_w[k];
    end else begin : g_mid_r
      assign right_w = data_w[k+1];
    end
    ile_cell #(
      .INDEX    (k),
      .ITEM_BITS(ITEM_BITS),
      .IW       (IW),
      .CW       (CW)
    ) u_cell (
      .clk_i  (clk_i),
      .op_i   (op),
      .idx_i  (idx),
      .count_i(count_q),
      .value_i(item_value_i),
      .left_i (left_w),
      .right_i(right_w),
      .data_o (data_w[k]),
      .rd_o   (rd_w[k]),
      .match_o(match_w[k])
    );
  end

  // only the addressed cell drives a non-zero read word
  always_comb begin
    rd_any = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_any = rd_any | rd_w[k];
    end
  end
  assign hit_any = |match_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q      <= rd_d;
      found_q   <= found_d;
      cnt_out_q <= count_d;
      status_q  <= status_d;
    end
  end

  assign done_o       = done_q;
  assign read_value_o = rd_q;
  assign found_o      = found_q;
  assign item_count_o = cnt_out_q;
  assign status_o     = status_q;

endmodule

@@ sv/ile_cell.sv @@
// one storage cell of the list engine: holds one element, shifts with its neighbours
// depends on ile_pkg
module ile_cell #(
  parameter int unsigned INDEX     = 0,
  parameter int unsigned ITEM_BITS = 32,
  parameter int unsigned IW        = 6,
  parameter int unsigned CW        = 7
) (
  input  logic                 clk_i,
  input  ile_pkg::cell_op_e    op_i,
  input  logic [IW-1:0]        idx_i,
  input  logic [CW-1:0]        count_i,
  input  logic [ITEM_BITS-1:0] value_i,
  input  logic [ITEM_BITS-1:0] left_i,
  input  logic [ITEM_BITS-1:0] right_i,
  output logic [ITEM_BITS-1:0] data_o,
  output logic [ITEM_BITS-1:0] rd_o,
  output logic                 match_o
);
  import ile_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(INDEX);
  localparam logic [CW-1:0] MY_POS = CW'(INDEX);

  logic [ITEM_BITS-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    unique case (op_i)
      CELL_HOLD: data_d = data_q;
      CELL_INS: begin
        if (MY_IDX > idx_i) begin
          data_d = left_i;
        end else if (MY_IDX == idx_i) begin
          data_d = value_i;
        end
      end
      // cells at and above the hole take the word from the right
      CELL_DEL: begin
        if (MY_IDX >= idx_i) begin
          data_d = right_i;
        end
      end
      CELL_WR: begin
        if (MY_IDX == idx_i) begin
          data_d = value_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign rd_o    = (MY_IDX == idx_i) ? data_q : '0;
  assign match_o = (MY_POS < count_i) && (data_q == value_i);

endmodule

@@ sv/ile_checker.sv @@
// port-level checks on the list engine, bound to its top level
// depends on ile_pkg and indexed_list_engine_unit_assert.svh
`include "indexed_list_engine_unit_assert.svh"

module ile_checker #(
  parameter int unsigned CAPACITY  = 64,
  parameter int unsigned ITEM_BITS = 32
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start,
  input logic                               busy,
  input logic                               done_o,
  input logic [ITEM_BITS-1:0]               read_value_o,
  input logic                               found_o,
  input logic [$clog2(CAPACITY+1)-1:0]      item_count_o,
  input logic [ile_pkg::STATUS_W-1:0]       status_o
);
  import ile_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  // one result for every accepted word, none otherwise
  `ILE_ASSERT(a_result_follows, (start && !busy) |=> done_o, "accepted word gave no result")
  `ILE_ASSERT(a_no_spurious, !(start && !busy) |=> !done_o, "result without a command")
  `ILE_ASSERT(a_count_bound, done_o |-> (item_count_o <= CAP_C), "count above capacity")
  `ILE_ASSERT(a_full_count, (done_o && status_o == ST_FULL) |-> (item_count_o == CAP_C),
              "full status with room left")
  `ILE_ASSERT(a_found_clean, (done_o && found_o) |-> (status_o == ST_OK && read_value_o == '0),
              "query hit carries read data or an error")

endmodule

bind indexed_list_engine_unit ile_checker #(
  .CAPACITY (CAPACITY),
  .ITEM_BITS(ITEM_BITS)
) u_ile_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .done_o      (done_o),
  .read_value_o(read_value_o),
  .found_o     (found_o),
  .item_count_o(item_count_o),
  .status_o    (status_o)
);

@@ tb/tb.sv @@
// self-checking bench for indexed_list_engine_unit: directed table, then random command mix
// predicts untyped results from a shadow copy of the list; depends on ile_pkg and the block
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ile_pkg::*;

  localparam int unsigned LIST_DEPTH = 64;
  localparam int unsigned RANDOM_WORDS = 2000;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 4;

  // codes the block ignores
  localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

  typedef struct packed {
    logic [31:0]         read_value;
    logic                found;
    logic [6:0]          item_count;
    logic [STATUS_W-1:0] status;
  } list_result_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [6:0]       position;
    logic [31:0]      item_value;
    logic             typed;
    list_result_t     want;
  } list_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [CMD_W-1:0]    cmd_i = '0;
  logic [6:0]          position_i = '0;
  logic [31:0]         item_value_i = '0;
  logic                done_o;
  logic [31:0]         read_value_o;
  logic                found_o;
  logic [6:0]          item_count_o;
  logic [STATUS_W-1:0] status_o;

  indexed_list_engine_unit #(
    .CAPACITY (LIST_DEPTH),
    .ITEM_BITS(32)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .position_i  (position_i),
    .item_value_i(item_value_i),
    .done_o      (done_o),
    .read_value_o(read_value_o),
    .found_o     (found_o),
    .item_count_o(item_count_o),
    .status_o    (status_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow of the list contents
  logic [31:0]  shadow_list [LIST_DEPTH];
  int unsigned  shadow_count = 0;
  list_result_t expected_results [$];
  int unsigned  mismatches = 0;
  int unsigned  idle_cycles = 0;
  bit           busy_seen = 1'b1;
  bit           word_taken = 1'b0;
  int unsigned  burst_left = 0;

  localparam int unsigned DIRECTED_ROWS = 24;
  list_row_t directed_rows [DIRECTED_ROWS] = '{
    '{CMD_READ,   7'd1,   32'h0,        1'b1, '{32'h0, 1'b0, 7'd0, ST_RANGE}},
    '{CMD_REMOVE, 7'd0,   32'h0,        1'b1, '{32'h0, 1'b0, 7'd0, ST_RANGE}},
    '{CMD_MEMBER, 7'd0,   32'h0,        1'b1, '{32'h0, 1'b0, 7'd0, ST_OK}},
    '{CMD_SPARE6, 7'd127, 32'hffffffff, 1'b1, '{32'h0, 1'b0, 7'd0, ST_OK}},
    '{CMD_WRITE,  7'd1,   32'hffffffff, 1'b1, '{32'h0, 1'b0, 7'd0, ST_RANGE}},
    '{CMD_APPEND, 7'd0,   32'hffffffff, 1'b1, '{32'h0, 1'b0, 7'd1, ST_OK}},
    '{CMD_APPEND, 7'd127, 32'h0,        1'b1, '{32'h0, 1'b0, 7'd2, ST_OK}},
    '{CMD_INSERT, 7'd0,   32'h12345678, 1'b0, '0},
    '{CMD_INSERT, 7'd127, 32'ha5a5a5a5, 1'b0, '0},
    '{CMD_INSERT, 7'd2,   32'h5a5a5a5a, 1'b0, '0},
    '{CMD_INSERT, 7'd5,   32'h00c0ffee, 1'b0, '0},
    '{CMD_READ,   7'd1,   32'h0,        1'b0, '0},
    '{CMD_READ,   7'd6,   32'hffffffff, 1'b0, '0},
    '{CMD_READ,   7'd7,   32'h0,        1'b1, '{32'h0, 1'b0, 7'd6, ST_RANGE}},
    '{CMD_READ,   7'd127, 32'h0,        1'b1, '{32'h0, 1'b0, 7'd6, ST_RANGE}},
    '{CMD_WRITE,  7'd0,   32'h1,        1'b1, '{32'h0, 1'b0, 7'd6, ST_RANGE}},
    '{CMD_WRITE,  7'd6,   32'hdeadbeef, 1'b0, '0},
    '{CMD_MEMBER, 7'd127, 32'hffffffff, 1'b0, '0},
    '{CMD_MEMBER, 7'd3,   32'h13579bdf, 1'b0, '0},
    '{CMD_REMOVE, 7'd1,   32'h0,        1'b0, '0},
    '{CMD_REMOVE, 7'd5,   32'h0,        1'b0, '0},
    '{CMD_REMOVE, 7'd64,  32'h0,        1'b1, '{32'h0, 1'b0, 7'd4, ST_RANGE}},
    '{CMD_SPARE7, 7'd1,   32'h0,        1'b1, '{32'h0, 1'b0, 7'd4, ST_OK}},
    '{CMD_READ,   7'd4,   32'h0,        1'b0, '0}
  };

  // applies one command to the shadow list and returns the result it gives
  function automatic list_result_t apply_list_cmd(logic [CMD_W-1:0] c, logic [6:0] p,
                                                  logic [31:0] v);
    list_result_t r;
    int unsigned  i;
    bit           in_range;
    r = '0;
    r.status = ST_OK;
    in_range = (p >= 1) && (p <= shadow_count);
    case (c)
      CMD_APPEND: begin
        if (shadow_count >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_list[shadow_count] = v;
          shadow_count++;
        end
      end
      CMD_INSERT: begin
        if (shadow_count >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // slot at or past the end appends
          for (i = shadow_count; i > p; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[(p >= shadow_count) ? shadow_count : p] = v;
          shadow_count++;
        end
      end
      CMD_REMOVE: begin
        if (!in_range) begin
          r.status = ST_RANGE;
        end else begin
          for (i = p; i < shadow_count; i++) shadow_list[i-1] = shadow_list[i];
          shadow_count--;
        end
      end
      CMD_READ: begin
        if (!in_range) r.status = ST_RANGE;
        else r.read_value = shadow_list[p-1];
      end
      CMD_WRITE: begin
        if (!in_range) r.status = ST_RANGE;
        else shadow_list[p-1] = v;
      end
      CMD_MEMBER: begin
        for (i = 0; i < shadow_count; i++) begin
          if (shadow_list[i] == v) r.found = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.item_count = shadow_count[6:0];
    return r;
  endfunction

  // holds start until the word is taken, then records what should come back
  task automatic send_list_cmd(logic [CMD_W-1:0] c, logic [6:0] p, logic [31:0] v,
                               bit typed, list_result_t want);
    list_result_t predicted;
    cmd_i <= c;
    position_i <= p;
    item_value_i <= v;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy_seen) @(posedge clk_i);
    predicted = apply_list_cmd(c, p, v);
    expected_results.push_back(typed ? want : predicted);
    word_taken = 1'b1;
  endtask

  // sender gap: mostly none, some short, a few long, with bursts of none at all
  task automatic sender_gap();
    int unsigned roll;
    int unsigned gap;
    roll = $urandom_range(0, 99);
    if (burst_left == 0 && roll < 2) burst_left = $urandom_range(20, 60);
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else if (roll < 60) begin
      gap = 0;
    end else if (roll < 90) begin
      gap = $urandom_range(1, 3);
    end else if (roll < 98) begin
      gap = $urandom_range(4, 10);
    end else begin
      gap = $urandom_range(20, 40);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [6:0] pick_position(bit for_insert);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) begin
      if (for_insert) return 7'($urandom_range(0, shadow_count));
      if (shadow_count == 0) return 7'd1;
      return 7'($urandom_range(1, shadow_count));
    end
    if (roll < 88) return 7'd0;
    if (roll < 94) return 7'(shadow_count + 1);
    return 7'($urandom_range(0, 127));
  endfunction

  function automatic logic [31:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return $urandom;
    if (roll < 70) return 32'h1000_0000 + $urandom_range(0, 7);
    if (roll < 75) return 32'h0;
    if (roll < 80) return 32'hffffffff;
    if (shadow_count == 0) return $urandom;
    return shadow_list[$urandom_range(0, shadow_count - 1)];
  endfunction

  // command mix leans towards growth until the list fills, then towards removal
  function automatic logic [CMD_W-1:0] pick_cmd(bit growing);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (growing) begin
      if (roll < 30) return CMD_APPEND;
      if (roll < 55) return CMD_INSERT;
      if (roll < 63) return CMD_REMOVE;
    end else begin
      if (roll < 8) return CMD_APPEND;
      if (roll < 15) return CMD_INSERT;
      if (roll < 63) return CMD_REMOVE;
    end
    if (roll < 75) return CMD_READ;
    if (roll < 85) return CMD_WRITE;
    if (roll < 97) return CMD_MEMBER;
    return (roll < 98) ? CMD_SPARE6 : CMD_SPARE7;
  endfunction

  // result side and watchdog, sampled mid-cycle
  always @(negedge clk_i) begin
    list_result_t want;
    busy_seen = busy;
    if (rst_ni && done_o === 1'b1) begin
      if (expected_results.size() == 0) begin
        $error("result word with none expected");
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (read_value_o !== want.read_value) begin
          $error("read_value: expected %h, got %h", want.read_value, read_value_o);
          mismatches++;
        end
        if (found_o !== want.found) begin
          $error("found: expected %b, got %b", want.found, found_o);
          mismatches++;
        end
        if (item_count_o !== want.item_count) begin
          $error("item_count: expected %0d, got %0d", want.item_count, item_count_o);
          mismatches++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          mismatches++;
        end
      end
    end
    if (word_taken || (rst_ni && done_o === 1'b1)) idle_cycles = 0;
    else idle_cycles++;
    word_taken = 1'b0;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    int unsigned n;
    bit          growing;
    logic [CMD_W-1:0] c;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (n = 0; n < DIRECTED_ROWS; n++) begin
      send_list_cmd(directed_rows[n].cmd, directed_rows[n].position,
                    directed_rows[n].item_value, directed_rows[n].typed,
                    directed_rows[n].want);
      sender_gap();
    end
    growing = 1'b1;
    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (shadow_count == 0) growing = 1'b1;
      else if (shadow_count == LIST_DEPTH && $urandom_range(0, 99) < 15) growing = 1'b0;
      c = pick_cmd(growing);
      send_list_cmd(c, pick_position(c == CMD_INSERT), pick_value(), 1'b0, '0);
      sender_gap();
    end
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
